[rtl/packet_flow_table_defines.svh]
// Assertion macros for the flow table checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef PACKET_FLOW_TABLE_DEFINES_SVH
`define PACKET_FLOW_TABLE_DEFINES_SVH

// same-cycle implication
`define PFT_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PFT_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/pft_pkg.sv]
// Shared types and constants of the flow table block.
// No dependencies.
`timescale 1ns / 1ps

package pft_pkg;

	localparam int FLOW_ENTRIES = 64;
	localparam int IDX_W        = $clog2(FLOW_ENTRIES);
	localparam int CNT_W        = $clog2(FLOW_ENTRIES + 1);

	localparam int TS_W         = 63;
	localparam int IN_TDATA_W   = 216;
	localparam int OUT_TDATA_W  = 192;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_NUM_ICMP = 8'd1;
	localparam logic [7:0]  PROTO_NUM_TCP  = 8'd6;
	localparam logic [7:0]  PROTO_NUM_UDP  = 8'd17;

	localparam logic [1:0]  CLASS_ICMP = 2'd0;
	localparam logic [1:0]  CLASS_TCP  = 2'd1;
	localparam logic [1:0]  CLASS_UDP  = 2'd2;

	localparam logic [7:0]  TCP_FLAG_MASK = 8'h3F;

	// configuration register indexes
	localparam logic REG_WINDOW_START  = 1'b0;
	localparam logic REG_WINDOW_LENGTH = 1'b1;

	// func field
	localparam logic FUNC_COUNT = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	typedef enum logic [2:0] {
		RES_HIT        = 3'd0,
		RES_NEW        = 3'd1,
		RES_FILTERED   = 3'd2,
		RES_FULL       = 3'd3,
		RES_READ_OK    = 3'd4,
		RES_READ_EMPTY = 3'd5
	} result_code_t;

	typedef struct packed {
		logic        func;
		logic [15:0] ethertype;
		logic [7:0]  ip_protocol;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [15:0] frame_len;
		logic [7:0]  proto_state_in;
		logic [TS_W-1:0] timestamp_us;
		logic [5:0]  read_index;
	} pkt_item_t;

	// one table entry as stored in the RAM
	typedef struct packed {
		logic [1:0]  proto;
		logic [63:0] addrs;   // src high, dst low
		logic [31:0] ports;   // src high, dst low
		logic [31:0] packets;
		logic [47:0] bytes;
		logic [7:0]  pstate;
	} entry_t;

	typedef struct packed {
		logic         capture;
		logic         scan_start;
		logic         scan_step;
		logic         read_issue;
		logic         wr_update;
		logic         wr_new;
		logic         out_load;
		result_code_t out_code;
	} pft_cmd_t;

	typedef struct packed {
		logic is_read;
		logic keep;
		logic read_in_range;
		logic scan_done;
		logic match;
		logic full;
	} pft_stat_t;

endpackage

[rtl/pft_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module pft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[rtl/pft_ctrl.sv]
// Controller of the flow table: sequences filter, search, update, read and output.
// Depends on pft_pkg.
`timescale 1ns / 1ps

module pft_ctrl import pft_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_tvalid,
	output logic      in_tready,
	output logic      out_tvalid,
	input  logic      out_tready,
	input  pft_stat_t stat,
	output pft_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SEARCH,
		S_HIT,
		S_MISS,
		S_RDOUT,
		S_BLANK
	} state_t;

	state_t       state_q;
	result_code_t code_q;
	logic         out_valid_q;
	logic         slot_free;

	assign slot_free  = !out_valid_q || out_tready;
	assign in_tready  = (state_q == S_IDLE);
	assign out_tvalid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.out_code = code_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = in_tvalid;
			end
			S_CHECK: begin
				cmd.read_issue = stat.is_read && stat.read_in_range;
				cmd.scan_start = !stat.is_read && stat.keep;
			end
			S_SEARCH: begin
				cmd.scan_step = !stat.match && !stat.scan_done;
			end
			S_HIT: begin
				if (slot_free) begin
					cmd.wr_update = 1'b1;
					cmd.out_load  = 1'b1;
					cmd.out_code  = RES_HIT;
				end
			end
			S_MISS: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					if (stat.full) begin
						cmd.out_code = RES_FULL;
					end else begin
						cmd.wr_new   = 1'b1;
						cmd.out_code = RES_NEW;
					end
				end
			end
			S_RDOUT: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					cmd.out_code = RES_READ_OK;
				end
			end
			S_BLANK: begin
				cmd.out_load = slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			code_q      <= RES_FILTERED;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_tvalid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (stat.is_read) begin
						if (stat.read_in_range) begin
							state_q <= S_RDOUT;
						end else begin
							code_q  <= RES_READ_EMPTY;
							state_q <= S_BLANK;
						end
					end else if (stat.keep) begin
						state_q <= S_SEARCH;
					end else begin
						code_q  <= RES_FILTERED;
						state_q <= S_BLANK;
					end
				end
				S_SEARCH: begin
					if (stat.match) begin
						state_q <= S_HIT;
					end else if (stat.scan_done) begin
						state_q <= S_MISS;
					end
				end
				S_HIT, S_MISS, S_RDOUT, S_BLANK: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/pft_dp.sv]
// Datapath of the flow table: item registers, window filter, table RAM,
// scan counter, key compare, counter update and output register.
// Depends on pft_pkg and pft_ram.
`timescale 1ns / 1ps

module pft_dp import pft_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic                   cfg_index,
	input  logic [TS_W-1:0]        cfg_data,
	input  pkt_item_t              item,
	input  pft_cmd_t               cmd,
	output pft_stat_t              stat,
	output logic [2:0]             res_code,
	output logic [OUT_TDATA_W-1:0] res_data
);

	logic [TS_W-1:0] win_start_q;
	logic [TS_W-1:0] win_len_q;
	pkt_item_t       item_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_q;
	logic             cmp_valid_s1;
	logic [IDX_W-1:0] cmp_idx_s1;

	logic [TS_W-1:0]  ts_delta;
	logic             in_window;
	logic             proto_ok;
	logic [1:0]       cls;
	logic [7:0]       new_state;
	logic [31:0]      key_ports;
	entry_t           rd_entry;
	entry_t           upd_entry;
	entry_t           new_entry;
	entry_t           wr_entry;
	logic [48:0]      byte_sum;
	logic [IDX_W-1:0] count_idx;
	logic [IDX_W-1:0] ridx;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic [$bits(entry_t)-1:0] rd_raw;

	assign count_idx = count_q[IDX_W-1:0];
	assign ridx      = item_q.read_index[IDX_W-1:0];

	// classify the held item
	always_comb begin
		proto_ok  = 1'b1;
		cls       = CLASS_UDP;
		new_state = 8'd0;
		key_ports = {item_q.src_port, item_q.dst_port};
		unique case (item_q.ip_protocol)
			PROTO_NUM_ICMP: begin
				cls       = CLASS_ICMP;
				new_state = item_q.proto_state_in;
				key_ports = 32'd0;
			end
			PROTO_NUM_TCP: begin
				cls       = CLASS_TCP;
				new_state = item_q.proto_state_in & TCP_FLAG_MASK;
			end
			PROTO_NUM_UDP: begin
				cls = CLASS_UDP;
			end
			default: begin
				proto_ok = 1'b0;
			end
		endcase
	end

	assign ts_delta  = item_q.timestamp_us - win_start_q;
	assign in_window = (item_q.timestamp_us > win_start_q) && (ts_delta <= win_len_q);

	assign rd_entry = entry_t'(rd_raw);

	// hit update, saturating counters
	always_comb begin
		upd_entry = rd_entry;
		byte_sum  = {1'b0, rd_entry.bytes} + 49'(item_q.frame_len);
		if (rd_entry.packets != 32'hFFFF_FFFF) begin
			upd_entry.packets = rd_entry.packets + 32'd1;
		end
		upd_entry.bytes = byte_sum[48] ? 48'hFFFF_FFFF_FFFF : byte_sum[47:0];
		if (rd_entry.proto != CLASS_UDP) begin
			upd_entry.pstate = new_state;
		end
	end

	always_comb begin
		new_entry.proto   = cls;
		new_entry.addrs   = {item_q.src_addr, item_q.dst_addr};
		new_entry.ports   = key_ports;
		new_entry.packets = 32'd1;
		new_entry.bytes   = 48'(item_q.frame_len);
		new_entry.pstate  = new_state;
	end

	assign wr_entry = cmd.wr_update ? upd_entry : new_entry;
	assign wr_addr  = cmd.wr_update ? cmp_idx_s1 : count_idx;
	assign rd_addr  = cmd.read_issue ? ridx : scan_q[IDX_W-1:0];

	pft_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(FLOW_ENTRIES)
	) u_table (
		.clk    (clk),
		.wr_en  (cmd.wr_update || cmd.wr_new),
		.wr_addr(wr_addr),
		.wr_data(wr_entry),
		.rd_en  (cmd.scan_step || cmd.read_issue),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);

	always_comb begin
		stat.is_read       = (item_q.func == FUNC_READ);
		stat.keep          = in_window && (item_q.ethertype == ETHERTYPE_IPV4) && proto_ok;
		stat.read_in_range = {1'b0, ridx} < count_q;
		stat.scan_done     = (scan_q == count_q);
		stat.full          = (count_q == CNT_W'(FLOW_ENTRIES));
		stat.match         = cmp_valid_s1 && (rd_entry.proto == cls) &&
		                     (rd_entry.addrs == new_entry.addrs) && (rd_entry.ports == key_ports);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start_q  <= '0;
			win_len_q    <= '0;
			count_q      <= '0;
			scan_q       <= '0;
			cmp_valid_s1 <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == REG_WINDOW_START) begin
					win_start_q <= cfg_data;
				end else begin
					win_len_q <= cfg_data;
				end
			end
			if (cmd.scan_start) begin
				scan_q <= '0;
			end else if (cmd.scan_step) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			cmp_valid_s1 <= cmd.scan_step;
			if (cmd.wr_new) begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.scan_step) begin
			cmp_idx_s1 <= scan_q[IDX_W-1:0];
		end
	end

	// output register: index in the low bits, then the entry fields
	entry_t           out_entry;
	logic [IDX_W-1:0] out_idx;
	logic [2:0]       res_code_q;
	logic [OUT_TDATA_W-1:0] res_data_q;

	always_comb begin
		out_entry = '0;
		out_idx   = '0;
		unique case (cmd.out_code)
			RES_HIT: begin
				out_entry = upd_entry;
				out_idx   = cmp_idx_s1;
			end
			RES_NEW: begin
				out_entry = new_entry;
				out_idx   = count_idx;
			end
			RES_READ_OK: begin
				out_entry = rd_entry;
				out_idx   = ridx;
			end
			RES_READ_EMPTY: begin
				out_idx = ridx;
			end
			default: begin
				out_entry = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_code_q <= cmd.out_code;
			res_data_q <= {out_entry.pstate, out_entry.bytes, out_entry.packets,
			               out_entry.ports[15:0], out_entry.ports[31:16],
			               out_entry.addrs[31:0], out_entry.addrs[63:32],
			               out_entry.proto, 6'(out_idx)};
		end
	end

	assign res_code = res_code_q;
	assign res_data = res_data_q;

endmodule

[rtl/packet_flow_table.sv]
// Top level of the five-tuple flow table.
// Depends on pft_pkg, pft_ctrl, pft_dp and pft_ram.
`timescale 1ns / 1ps
//
// Usage:
//   s_axis carries one item per transaction: tuser selects count (0) or read
//   (1), tdata holds the parsed header, timestamp and read index. m_axis
//   returns exactly one result per item: status code in tuser, entry in tdata.
//   User writes window registers via cfg_* only while block idle; unchecked.
// Timing:
//   A counted packet scans the table one entry per cycle through the
//   registered RAM read port. One item is in flight at a time;
//   s_axis_tready rises the cycle after the result is loaded.
// Reset:
//   Clears the window registers and entry count; table contents are not
//   cleared, entries past the count are never shown.
// Backpressure:
//   A result holds in the output register while m_axis_tready is low; the
//   next item is accepted meanwhile and waits at its final step for the slot.

module packet_flow_table import pft_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic                   cfg_index,
	input  logic [TS_W-1:0]        cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// ethertype, ip_protocol, src_addr, dst_addr, src_port, dst_port,
	// frame_len, proto_state_in, timestamp_us, read_index, zero pad
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// func
	input  logic                   s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// flow_index, protocol_class, flow_src_addr, flow_dst_addr, flow_src_port,
	// flow_dst_port, packet_count, byte_count, flow_state
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// status
	output logic [2:0]             m_axis_tuser
);

	pkt_item_t item;
	pft_cmd_t  cmd;
	pft_stat_t stat;

	always_comb begin
		item.func           = s_axis_tuser;
		item.ethertype      = s_axis_tdata[15:0];
		item.ip_protocol    = s_axis_tdata[23:16];
		item.src_addr       = s_axis_tdata[55:24];
		item.dst_addr       = s_axis_tdata[87:56];
		item.src_port       = s_axis_tdata[103:88];
		item.dst_port       = s_axis_tdata[119:104];
		item.frame_len      = s_axis_tdata[135:120];
		item.proto_state_in = s_axis_tdata[143:136];
		item.timestamp_us   = s_axis_tdata[206:144];
		item.read_index     = s_axis_tdata[212:207];
	end

	pft_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tvalid (s_axis_tvalid),
		.in_tready (s_axis_tready),
		.out_tvalid(m_axis_tvalid),
		.out_tready(m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pft_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.item     (item),
		.cmd      (cmd),
		.stat     (stat),
		.res_code (m_axis_tuser),
		.res_data (m_axis_tdata)
	);

endmodule

[rtl/pft_checker.sv]
// Port-level checks of the flow table, bound to the top level.
// Depends on pft_pkg and packet_flow_table_defines.svh.
`timescale 1ns / 1ps
`include "packet_flow_table_defines.svh"

module pft_checker import pft_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [2:0]             m_axis_tuser
);

	// one item at a time: no accept right after an accept
	`PFT_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "accepted twice in a row")

	`PFT_ASSERT_NOW(a_status_range, m_axis_tvalid, m_axis_tuser <= 3'(RES_READ_EMPTY), "status code out of range")

	// filtered and dropped transactions carry no entry
	`PFT_ASSERT_NOW(a_blank_drop, m_axis_tvalid && (m_axis_tuser == 3'(RES_FILTERED) || m_axis_tuser == 3'(RES_FULL)), m_axis_tdata == '0, "dropped result not blank")

	`PFT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind packet_flow_table pft_checker u_pft_checker (.*);
